FILE: rtl/dns_query_encoder_top_assert.svh
// assertion macros for the dns query encoder
// included by the rtl files that carry concurrent checks; no other dependency
`ifndef DNS_QUERY_ENCODER_TOP_ASSERT_SVH
`define DNS_QUERY_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DQE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DQE_NEVER(lbl, cond, msg) `DQE_ASSERT(lbl, !(cond), msg)
`else
`define DQE_ASSERT(lbl, prop, msg)
`define DQE_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/dqe_pkg.sv
// shared types and constants for the dns query encoder
// used by every rtl module of the block; no dependencies
package dqe_pkg;

  localparam int MAX_LABEL   = 63;
  localparam int STORE_DEPTH = 64;
  localparam int LEN_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = LEN_W;
  localparam int HDR_BYTES   = 12;
  localparam int CLOSE_BYTES = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  DOT_CHAR    = 8'd46;
  // qr bit 15 and opcode at bit 11 stay zero, rd is bit 8
  localparam logic [15:0] HDR_FLAGS   = (16'd0 << 15) | (16'd0 << 11) | (16'd1 << 8);
  localparam logic [15:0] HDR_QDCOUNT = 16'd1;

  localparam logic [1:0] BC_ONE = 2'd1;
  localparam logic [1:0] BC_TWO = 2'd2;

  typedef enum logic [1:0] {
    CK_NONE,
    CK_STORE,
    CK_DOT
  } char_kind_t;

  typedef struct packed {
    logic [7:0]  name_char;
    logic        char_valid;
    logic        first;
    logic        last;
    logic [15:0] query_id;
    logic [15:0] query_type;
    logic [15:0] query_class;
  } item_t;

  typedef struct packed {
    logic [15:0] out_data;
    logic [1:0]  byte_count;
    logic        run_end;
    logic        message_end;
  } result_t;

  // classified word handed from front to back
  typedef struct packed {
    logic        first;
    logic        last;
    char_kind_t  kind;
    logic [7:0]  ch;
    logic [15:0] id;
    logic [15:0] qtype;
    logic [15:0] qclass;
  } cmd_t;

  // one message byte with its end marks
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       message_end;
  } msg_byte_t;

endpackage

FILE: rtl/dns_query_encoder_top.sv
// top level of the dns query encoder
// depends on dqe_pkg, dqe_front, dqe_back and dqe_pack
//
// Builds a dns query message (12-byte header plus one question without
// the echo record) from a hostname fed one character per input word.
// A word with first set emits the header (id, flags with only rd set,
// qdcount 1, other counts 0) and samples type and class; characters are
// collected into a label of at most 63 bytes, a dot or last writes the
// label out as a length byte plus its bytes (empty labels vanish), and
// last then appends a zero byte, type and class, all big-endian. Bytes
// come out up to two per result word, earlier byte in the upper half; run_end
// marks the final word caused by an input word and message_end the
// final word of the message. Words that produce no bytes produce no
// result. The back end sequencer emits one byte per cycle while the
// packer accepts it; it dequeues each command in its idle state, then
// sends any header bytes, handles the character and sends any flushed
// label and closing bytes; the 2-entry command queue lets the input
// side run ahead meanwhile, and one output register lets the sequencer
// keep going while a result waits to be popped. There is no clearing
// pass after reset.
module dns_query_encoder_top
  import dqe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  // input queue side
  input  logic    push,
  output logic    full,
  input  item_t   item,
  // result queue side
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  // front to back command queue
  logic      cmd_valid;
  logic      cmd_pop;
  cmd_t      cmd;

  // back to packer byte stream
  logic      byte_valid;
  logic      byte_ready;
  msg_byte_t msg_byte;

  // classify and queue input words
  dqe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // header, label buffering and flushing, closing bytes
  dqe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_out   (msg_byte)
  );

  // pair bytes into result words
  dqe_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_in    (msg_byte),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

FILE: rtl/dqe_front.sv
// front end: takes input words, classifies the character, queues commands
// depends on dqe_pkg
module dqe_front
  import dqe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output logic  cmd_valid,
  input  logic  cmd_pop,
  output cmd_t  cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;
  logic [CNT_QW-1:0] count_next;
  logic              push_ok;
  logic              pop_ok;
  cmd_t              new_cmd;

  assign full      = (count == CNT_QW'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_pop && cmd_valid;

  // classify the character
  always_comb begin
    new_cmd.first  = item.first;
    new_cmd.last   = item.last;
    new_cmd.ch     = item.name_char;
    new_cmd.id     = item.query_id;
    new_cmd.qtype  = item.query_type;
    new_cmd.qclass = item.query_class;
    if (!item.char_valid) begin
      new_cmd.kind = CK_NONE;
    end else if (item.name_char == DOT_CHAR) begin
      new_cmd.kind = CK_DOT;
    end else begin
      new_cmd.kind = CK_STORE;
    end
  end

  always_comb begin
    count_next = count + CNT_QW'(push_ok) - CNT_QW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      queue[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

endmodule

FILE: rtl/dqe_back.sv
// back end: sequencer that turns commands into message bytes, owns the label memory
// depends on dqe_pkg and dns_query_encoder_top_assert.svh
`include "dns_query_encoder_top_assert.svh"
module dqe_back
  import dqe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  input  cmd_t      cmd,
  output logic      byte_valid,
  input  logic      byte_ready,
  output msg_byte_t byte_out
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_HDR   = 6'b000010,
    ST_CHAR  = 6'b000100,
    ST_FLEN  = 6'b001000,
    ST_FDATA = 6'b010000,
    ST_CLOSE = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  cmd_t              cur;
  logic [15:0]       held_type;
  logic [15:0]       held_class;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  len_next;
  logic [LEN_W-1:0]  len_after;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [7:0]        label_mem [STORE_DEPTH];
  logic [7:0]        rdata;
  logic              mem_we;
  logic              rd_en;
  logic [LEN_W-1:0]  rd_addr;
  logic              load_cur;
  logic              load_held;
  logic              flush_go;

  function automatic logic [7:0] hdr_byte(input logic [CNT_W-1:0] idx,
                                          input logic [15:0] id);
    logic [7:0] b;
    case (idx)
      CNT_W'(0): b = id[15:8];
      CNT_W'(1): b = id[7:0];
      CNT_W'(2): b = HDR_FLAGS[15:8];
      CNT_W'(3): b = HDR_FLAGS[7:0];
      CNT_W'(4): b = HDR_QDCOUNT[15:8];
      CNT_W'(5): b = HDR_QDCOUNT[7:0];
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] close_byte(input logic [CNT_W-1:0] idx,
                                            input logic [15:0] qt,
                                            input logic [15:0] qc);
    logic [7:0] b;
    case (idx)
      CNT_W'(1): b = qt[15:8];
      CNT_W'(2): b = qt[7:0];
      CNT_W'(3): b = qc[15:8];
      CNT_W'(4): b = qc[7:0];
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    len_next   = len;
    len_after  = len;
    flush_go   = 1'b0;
    cmd_pop    = 1'b0;
    load_cur   = 1'b0;
    load_held  = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = LEN_W'(cnt);
    byte_valid = 1'b0;
    byte_out   = '0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          load_cur = 1'b1;
          cnt_next = '0;
          if (cmd.first) begin
            load_held  = 1'b1;
            len_next   = '0;
            state_next = ST_HDR;
          end else begin
            state_next = ST_CHAR;
          end
        end
      end
      ST_HDR: begin
        byte_valid           = 1'b1;
        byte_out.data        = hdr_byte(cnt, cur.id);
        byte_out.run_end     = (cnt == CNT_W'(HDR_BYTES - 1)) && !cur.last;
        if (byte_ready) begin
          if (cnt == CNT_W'(HDR_BYTES - 1)) begin
            cnt_next   = '0;
            state_next = ST_CHAR;
          end else begin
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
      ST_CHAR: begin
        // store the character unless the label is already full
        if (cur.kind == CK_STORE && len < LEN_W'(MAX_LABEL)) begin
          mem_we    = 1'b1;
          len_after = len + LEN_W'(1);
        end
        flush_go = (cur.kind == CK_DOT || cur.last) && (len_after != '0);
        len_next = len_after;
        cnt_next = '0;
        if (flush_go) begin
          state_next = ST_FLEN;
        end else if (cur.last) begin
          state_next = ST_CLOSE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FLEN: begin
        byte_valid    = 1'b1;
        byte_out.data = 8'(len);
        if (byte_ready) begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          cnt_next   = '0;
          state_next = ST_FDATA;
        end
      end
      ST_FDATA: begin
        byte_valid       = 1'b1;
        byte_out.data    = rdata;
        byte_out.run_end = (LEN_W'(cnt) == len - LEN_W'(1)) && !cur.last;
        if (byte_ready) begin
          if (LEN_W'(cnt) == len - LEN_W'(1)) begin
            len_next   = '0;
            cnt_next   = '0;
            state_next = cur.last ? ST_CLOSE : ST_IDLE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = LEN_W'(cnt) + LEN_W'(1);
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
      ST_CLOSE: begin
        byte_valid           = 1'b1;
        byte_out.data        = close_byte(cnt, held_type, held_class);
        byte_out.run_end     = (cnt == CNT_W'(CLOSE_BYTES - 1));
        byte_out.message_end = (cnt == CNT_W'(CLOSE_BYTES - 1));
        if (byte_ready) begin
          if (cnt == CNT_W'(CLOSE_BYTES - 1)) begin
            cnt_next   = '0;
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // label memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      label_mem[len] <= cur.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= label_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      len        <= '0;
      held_type  <= '0;
      held_class <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      len   <= len_next;
      if (load_held) begin
        held_type  <= cmd.qtype;
        held_class <= cmd.qclass;
      end
    end
  end

  `DQE_ASSERT(a_pop_starts_item, cmd_pop |=> (state == ST_HDR || state == ST_CHAR), "bad state after dequeue")
  `DQE_NEVER(a_flush_empty, (state == ST_FDATA) && (len == '0), "flushing an empty label")
  `DQE_ASSERT(a_msg_end_close, (byte_valid && byte_out.message_end) |-> (byte_out.run_end && state == ST_CLOSE), "message end outside close")
  `DQE_ASSERT(a_hdr_first, (state == ST_HDR) |-> (cur.first && cnt < CNT_W'(HDR_BYTES)), "header without first")

endmodule

FILE: rtl/dqe_pack.sv
// byte packer: pairs message bytes into result words, holds one output word
// depends on dqe_pkg
module dqe_pack
  import dqe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  msg_byte_t byte_in,
  output logic      empty,
  input  logic      pop,
  output result_t   result
);

  logic       pend_v;
  logic [7:0] pend_data;
  logic       out_v;
  result_t    out_word;
  result_t    word_next;
  logic       needs_emit;
  logic       slot_free;
  logic       take;
  logic       emit;

  assign needs_emit = pend_v || byte_in.run_end;
  assign slot_free  = !out_v || pop;
  assign byte_ready = !needs_emit || slot_free;
  assign take       = byte_valid && byte_ready;
  assign emit       = take && needs_emit;
  assign empty      = !out_v;
  assign result     = out_word;

  // earlier byte in the upper half, a lone byte pads with zero
  always_comb begin
    if (pend_v) begin
      word_next.out_data   = {pend_data, byte_in.data};
      word_next.byte_count = BC_TWO;
    end else begin
      word_next.out_data   = {byte_in.data, 8'h00};
      word_next.byte_count = BC_ONE;
    end
    word_next.run_end     = byte_in.run_end;
    word_next.message_end = byte_in.message_end;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word <= word_next;
    end
    if (take && !needs_emit) begin
      pend_data <= byte_in.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (take) begin
        pend_v <= !needs_emit;
      end
      if (emit) begin
        out_v <= 1'b1;
      end else if (pop) begin
        out_v <= 1'b0;
      end
    end
  end

endmodule

FILE: test/dqe_message_check.sv
// scoreboard for the dns query encoder: predicts result words from accepted input words
// and compares them with the words popped from the block; depends on dqe_pkg
module dqe_message_check
  import dqe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    full,
  input  item_t   item,
  input  logic    empty,
  input  logic    pop,
  input  result_t result,
  output int      mismatches,
  output int      words_waiting,
  output int      words_checked
);

  logic [7:0]  label_bytes [STORE_DEPTH];
  logic [6:0]  label_len;
  logic [15:0] type_held;
  logic [15:0] class_held;
  logic [7:0]  msg_bytes [$];
  result_t     expected_words [$];
  int          fail_count = 0;
  int          checked_count = 0;

  function automatic void put_pair(input logic [15:0] w);
    msg_bytes.push_back(w[15:8]);
    msg_bytes.push_back(w[7:0]);
  endfunction

  // length byte plus label bytes; an empty label writes nothing
  function automatic void flush_label();
    if (label_len != 0) begin
      msg_bytes.push_back({1'b0, label_len});
      for (int i = 0; i < label_len; i++) msg_bytes.push_back(label_bytes[i]);
      label_len = '0;
    end
  endfunction

  // header, then the character, then the closing; bytes packed up to two per word
  function automatic void encode_word(input item_t w);
    result_t r;
    int      n;
    msg_bytes.delete();
    if (w.first) begin
      type_held  = w.query_type;
      class_held = w.query_class;
      label_len  = '0;
      put_pair(w.query_id);
      put_pair(HDR_FLAGS);
      put_pair(HDR_QDCOUNT);
      put_pair(16'h0000);
      put_pair(16'h0000);
      put_pair(16'h0000);
    end
    if (w.char_valid) begin
      if (w.name_char == DOT_CHAR) begin
        flush_label();
      end else if (label_len < MAX_LABEL) begin
        label_bytes[label_len[5:0]] = w.name_char;
        label_len = label_len + 7'd1;
      end
    end
    if (w.last) begin
      flush_label();
      msg_bytes.push_back(8'h00);
      put_pair(type_held);
      put_pair(class_held);
    end
    n = msg_bytes.size();
    for (int k = 0; k < n; k += 2) begin
      r.out_data    = {msg_bytes[k], (k + 1 < n) ? msg_bytes[k + 1] : 8'h00};
      r.byte_count  = (k + 1 < n) ? BC_TWO : BC_ONE;
      r.run_end     = (k + 2 >= n);
      r.message_end = r.run_end & w.last;
      expected_words.push_back(r);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      label_len  = '0;
      type_held  = '0;
      class_held = '0;
      expected_words.delete();
    end else begin
      if (push && !full) encode_word(item);
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: data %h count %0d run_end %b message_end %b",
                     result.out_data, result.byte_count, result.run_end, result.message_end);
        end else begin
          want = expected_words.pop_front();
          checked_count++;
          if (result.out_data !== want.out_data || result.byte_count !== want.byte_count ||
              result.run_end !== want.run_end || result.message_end !== want.message_end) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result word %0d mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                       checked_count, want.out_data, want.byte_count, want.run_end,
                       want.message_end, result.out_data, result.byte_count,
                       result.run_end, result.message_end);
          end
        end
      end
    end
    mismatches    <= fail_count;
    words_waiting <= expected_words.size();
    words_checked <= checked_count;
  end

endmodule

FILE: test/tb_dns_query_encoder_top.sv
// testbench top for the dns query encoder: clock, reset, stimulus and verdict
// depends on dqe_pkg, dns_query_encoder_top and dqe_message_check
module tb_dns_query_encoder_top;
  import dqe_pkg::*;

  // generous bound: a few hundred words, each at worst dozens of result words
  // under heavy stalling on both sides
  localparam int CYCLE_LIMIT  = 500000;
  // room for a last word with a full label to pass through the block
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_WORDS  = 60;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;

  int mismatches;
  int words_waiting;
  int words_checked;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int words_sent = 0;
  int names_sent = 0;
  int cycle_count = 0;

  dns_query_encoder_top dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  dqe_message_check u_message_check (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .mismatches    (mismatches),
    .words_waiting (words_waiting),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_dns_query_encoder_top: done, errors");
      $finish;
    end
  end

  // result side: pop dropped at random per the current stall rate
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  function automatic item_t make_word(input logic [7:0] ch, input logic valid,
                                      input logic first, input logic last,
                                      input logic [15:0] id, input logic [15:0] qtype,
                                      input logic [15:0] qclass);
    item_t w;
    w.name_char   = ch;
    w.char_valid  = valid;
    w.first       = first;
    w.last        = last;
    w.query_id    = id;
    w.query_type  = qtype;
    w.query_class = qclass;
    return w;
  endfunction

  // label character, never a dot so label lengths stay as planned
  function automatic logic [7:0] label_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == DOT_CHAR) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // hand one word over; idle cycles before it drop push, otherwise push stays
  // high from the previous word so it is never lowered and raised in one step
  task automatic send_word(input item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
  endtask

  // stop sending until the scoreboard holds no more expected words
  task automatic wait_all_results();
    push <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
  endtask

  // well-formed name with random content: first word, labels split by dots,
  // last word; with long_label one label of 62 to 70 characters nears or runs past the 63 byte cut
  task automatic send_name(input bit long_label);
    int    nlab;
    int    long_at;
    int    len;
    int    close_kind;
    item_t w;
    nlab    = $urandom_range(1, 4);
    long_at = long_label ? $urandom_range(0, nlab - 1) : -1;
    w = make_word(8'($urandom), 1'b0, 1'b1, 1'b0, 16'($urandom), 16'($urandom),
                  16'($urandom));
    // the first word sometimes carries the opening character
    if ($urandom_range(2) == 0) begin
      w.char_valid = 1'b1;
      w.name_char  = label_char();
    end
    send_word(w);
    for (int l = 0; l < nlab; l++) begin
      len = (l == long_at) ? $urandom_range(62, 70) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        // stray empty words inside the name
        if ($urandom_range(9) == 0)
          send_word(make_word(8'($urandom), 1'b0, 1'b0, 1'b0, 16'($urandom),
                              16'($urandom), 16'($urandom)));
        send_word(make_word(label_char(), 1'b1, 1'b0, 1'b0, 16'($urandom),
                            16'($urandom), 16'($urandom)));
      end
      if (l != nlab - 1)
        send_word(make_word(DOT_CHAR, 1'b1, 1'b0, 1'b0, 16'($urandom), 16'($urandom),
                            16'($urandom)));
    end
    // closing word: bare, with a last character, or with a trailing dot
    close_kind = $urandom_range(0, 2);
    w = make_word(8'($urandom), 1'b0, 1'b0, 1'b1, 16'($urandom), 16'($urandom),
                  16'($urandom));
    if (close_kind == 1) begin
      w.char_valid = 1'b1;
      w.name_char  = label_char();
    end else if (close_kind == 2) begin
      w.char_valid = 1'b1;
      w.name_char  = DOT_CHAR;
    end
    send_word(w);
    names_sent++;
  endtask

  // fully random word: broken sequences, stray first and last flags
  task automatic send_noise();
    logic [63:0] r;
    item_t       w;
    r = {$urandom, $urandom};
    w = r[$bits(item_t)-1:0];
    send_word(w);
  endtask

  initial begin
    rst  <= 1'b1;
    push <= 1'b0;
    pop  <= 1'b0;
    item <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: words before any first run on the reset type and class
    send_word(make_word("x", 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word(8'h00, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    // all-ones header fields, then character zero and 255 as label bytes
    send_word(make_word(8'hff, 1'b0, 1'b1, 1'b0, 16'hffff, 16'hffff, 16'hffff));
    send_word(make_word(8'h00, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word(8'hff, 1'b1, 1'b0, 1'b0, 16'hffff, 16'hffff, 16'hffff));
    // two-byte label gives an odd byte total, then an empty label
    send_word(make_word(DOT_CHAR, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word(DOT_CHAR, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    // a..b with a trailing dot on the last word
    send_word(make_word("a", 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word(DOT_CHAR, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word(DOT_CHAR, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word("b", 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word(DOT_CHAR, 1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    // all-zero header with a leading dot on the first word
    send_word(make_word(DOT_CHAR, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word("c", 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word("d", 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word(8'h00, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    // first and last on one word: header plus closing only
    send_word(make_word(8'h00, 1'b0, 1'b1, 1'b1, 16'ha5a5, 16'h0001, 16'h0001));
    // after a last with no new first: held type and class, no header
    send_word(make_word("z", 1'b1, 1'b0, 1'b0, 16'h1234, 16'h0000, 16'h0000));
    send_word(make_word("q", 1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    // character carried on the first word, an empty word, a bare last
    send_word(make_word("w", 1'b1, 1'b1, 1'b0, 16'h5a5a, 16'h001c, 16'h00ff));
    send_word(make_word(8'h5a, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word(8'ha5, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    wait_all_results();

    // random phases: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 80; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 80; end
        default: begin send_idle_pct = 24; pop_stall_pct = 24; end
      endcase
      // a long label, often past the cut, in two of the phases
      if (phase == 0 || phase == 2) send_name(1'b1);
      while (words_sent < 22 + PHASE_WORDS * (phase + 1)) begin
        if ($urandom_range(99) < 80) begin
          send_name(1'b0);
        end else begin
          repeat ($urandom_range(1, 3)) send_noise();
        end
      end
      // sender holds off until every expected word has come back
      wait_all_results();
    end

    push <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input words (%0d random names, noise and directed corners)",
             words_sent, names_sent);
    $display("%0d result words compared under four idle and stall mixes, %0d mismatches",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_dns_query_encoder_top: done, clean");
    end else begin
      $display("tb_dns_query_encoder_top: done, errors");
    end
    $finish;
  end

endmodule
